// ===== rtl/core/scc_pkg.sv =====
// Types, constants and arithmetic helpers for the spherical/cartesian converter.
`default_nettype none

package scc_pkg;

    localparam int DEF_CORDIC_STEPS = 24;
    localparam int XY_W = 56;
    localparam int Z_W = 34;
    localparam int SQRT_STEPS = 32;
    localparam int PRESCALE_SH = 20;

    localparam logic CMD_SPH2CART = 1'b0;
    localparam logic CMD_CART2SPH = 1'b1;

    localparam logic signed [Z_W-1:0] PI_Q28 = 34'sd843314857;
    localparam logic signed [Z_W-1:0] TWO_PI_Q28 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 56'sd652032874;
    localparam logic signed [67:0] Q16_MAX = 68'sd2147483647;
    localparam logic signed [67:0] Q16_MIN = -68'sd2147483648;

    typedef struct packed {
        logic neg;
        logic signed [Z_W-1:0] z;
    } ang_t;

    typedef struct packed {
        logic cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        ang_t th;
        ang_t ps;
        logic ok;
    } side_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
    } sqrt_t;

    typedef struct packed {
        sqrt_t rho;
        sqrt_t r;
    } sqrt2_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic cmd;
        logic signed [31:0] a;
        logic [31:0] r_clip;
        logic sat;
        logic ok;
        logic th_neg;
        logic ps_neg;
        logic signed [Z_W-1:0] off0;
        logic signed [Z_W-1:0] off1;
        logic zero0;
        logic zero1;
    } cord_side_t;

    typedef struct packed {
        logic [31:0] v;
        logic sat;
    } clip_t;

    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic signed [Z_W-1:0] v;
        v = '0;
        unique case (i)
            0: v = 34'sd210828714;
            1: v = 34'sd124459457;
            2: v = 34'sd65760959;
            3: v = 34'sd33381290;
            4: v = 34'sd16755422;
            5: v = 34'sd8385879;
            6: v = 34'sd4193963;
            7: v = 34'sd2097109;
            8: v = 34'sd1048571;
            9: v = 34'sd524287;
            default:
            begin
                if (i <= 28)
                begin
                    v = 34'sd1 <<< (28 - i);
                end
            end
        endcase
        return v;
    endfunction

    // Wraps by one whole turn at most (Q3.28 spans about +-8), then folds into +-PI/2.
    function automatic ang_t reduce_angle(input logic signed [31:0] a);
        ang_t r;
        r.z = Z_W'(a);
        r.neg = 1'b0;
        if (r.z > PI_Q28)
        begin
            r.z = r.z - TWO_PI_Q28;
        end
        else if (r.z < -PI_Q28)
        begin
            r.z = r.z + TWO_PI_Q28;
        end
        if (r.z > HALF_PI_Q28)
        begin
            r.z = r.z - PI_Q28;
            r.neg = 1'b1;
        end
        else if (r.z < -HALF_PI_Q28)
        begin
            r.z = r.z + PI_Q28;
            r.neg = 1'b1;
        end
        return r;
    endfunction

    function automatic sqrt_t sqrt_step(input sqrt_t s, input int k);
        logic [63:0] bval;
        logic [63:0] t;
        sqrt_t o;
        bval = 64'd1 << (62 - 2 * k);
        t = s.res + bval;
        if (s.rem >= t)
        begin
            o.rem = s.rem - t;
            o.res = (s.res >> 1) + bval;
        end
        else
        begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // Rotation drives z to zero, vectoring drives y to zero; shifts floor.
    function automatic cordic_t cordic_step(input cordic_t u, input logic rot, input int i);
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0] at;
        logic d;
        cordic_t o;
        xs = u.x >>> i;
        ys = u.y >>> i;
        at = atan_step(i);
        d = rot ? !u.z[Z_W-1] : u.y[XY_W-1];
        if (d)
        begin
            o.x = u.x - ys;
            o.y = u.y + xs;
            o.z = u.z - at;
        end
        else
        begin
            o.x = u.x + ys;
            o.y = u.y - xs;
            o.z = u.z + at;
        end
        return o;
    endfunction

    // Shift right by 30, rounding half away from zero.
    function automatic logic signed [67:0] rnd30(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v + 68'sd536870912;
        if (v[67])
        begin
            t = t - 68'sd1;
        end
        return t >>> 30;
    endfunction

    function automatic clip_t clip32(input logic signed [67:0] v);
        clip_t c;
        c.sat = 1'b0;
        c.v = v[31:0];
        if (v > Q16_MAX)
        begin
            c.sat = 1'b1;
            c.v = 32'h7FFF_FFFF;
        end
        else if (v < Q16_MIN)
        begin
            c.sat = 1'b1;
            c.v = 32'h8000_0000;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spherical_cartesian_convert.sv =====
// Pipelined spherical/cartesian vector converter built on shared CORDIC lanes.
`default_nettype none

// One vector word is taken in every cycle at which start is high; busy stays low
// because the pipeline never stalls. Each result word appears on the result ports
// for one cycle with done high. Each word passes through the 32-stage square root
// pipeline that runs before the CORDIC lanes, one root bit per stage, followed by
// CORDIC_STEPS rotation/vectoring stages and the multiply, round and clip stages.
module spherical_cartesian_convert #(
    parameter int CORDIC_STEPS = scc_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire logic               cmd,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    input  wire logic signed [31:0] operand_c,
    output      logic               done,
    output      logic signed [31:0] result_a,
    output      logic signed [31:0] result_b,
    output      logic signed [31:0] result_c,
    output      logic               in_range,
    output      logic               saturated
);

    localparam int NS = scc_pkg::SQRT_STEPS;
    localparam int LATENCY = 10 + NS + CORDIC_STEPS;

    // Input capture.
    logic s1_v_reg;
    logic s1_cmd_reg;
    logic signed [31:0] s1_a_reg;
    logic signed [31:0] s1_b_reg;
    logic signed [31:0] s1_c_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd;
        s1_a_reg <= operand_a;
        s1_b_reg <= operand_b;
        s1_c_reg <= operand_c;
    end

    // Squares, angle reduction and the range check.
    logic s2_v_reg;
    scc_pkg::side_t s2_side_reg;
    scc_pkg::side_t s2_side_next;
    logic [63:0] s2_sqa_reg;
    logic [63:0] s2_sqb_reg;
    logic [63:0] s2_sqc_reg;

    always_comb
    begin
        s2_side_next.cmd = s1_cmd_reg;
        s2_side_next.a = s1_a_reg;
        s2_side_next.b = s1_b_reg;
        s2_side_next.c = s1_c_reg;
        s2_side_next.th = scc_pkg::reduce_angle(s1_b_reg);
        s2_side_next.ps = scc_pkg::reduce_angle(s1_c_reg);
        s2_side_next.ok = !s1_a_reg[31]
            && (34'(s1_b_reg) >= -scc_pkg::PI_Q28) && (34'(s1_b_reg) <= scc_pkg::PI_Q28)
            && (34'(s1_c_reg) >= -scc_pkg::TWO_PI_Q28)
            && (34'(s1_c_reg) <= scc_pkg::TWO_PI_Q28);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s2_side_next;
        s2_sqa_reg <= 64'(64'(s1_a_reg) * 64'(s1_a_reg));
        s2_sqb_reg <= 64'(64'(s1_b_reg) * 64'(s1_b_reg));
        s2_sqc_reg <= 64'(64'(s1_c_reg) * 64'(s1_c_reg));
    end

    // Square root pipeline: one result bit per stage for rho and for the radius.
    logic sq_v_reg [0:NS];
    scc_pkg::side_t sq_side_reg [0:NS];
    scc_pkg::sqrt2_t sq_reg [0:NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else
        begin
            sq_v_reg[0] <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_side_reg[0] <= s2_side_reg;
        sq_reg[0].rho.rem <= s2_sqa_reg + s2_sqb_reg;
        sq_reg[0].rho.res <= '0;
        sq_reg[0].r.rem <= s2_sqa_reg + s2_sqb_reg + s2_sqc_reg;
        sq_reg[0].r.res <= '0;
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_side_reg[k+1] <= sq_side_reg[k];
            sq_reg[k+1].rho <= scc_pkg::sqrt_step(sq_reg[k].rho, k);
            sq_reg[k+1].r <= scc_pkg::sqrt_step(sq_reg[k].r, k);
        end
    end

    // Round both roots to nearest.
    logic rs_v_reg;
    scc_pkg::side_t rs_side_reg;
    logic [32:0] rs_rho_reg;
    logic [32:0] rs_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_v_reg <= 1'b0;
        end
        else
        begin
            rs_v_reg <= sq_v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        rs_side_reg <= sq_side_reg[NS];
        rs_rho_reg <= 33'(sq_reg[NS].rho.res)
            + 33'(sq_reg[NS].rho.rem > sq_reg[NS].rho.res);
        rs_r_reg <= 33'(sq_reg[NS].r.res) + 33'(sq_reg[NS].r.rem > sq_reg[NS].r.res);
    end

    // CORDIC lane setup: rotation from the gain for sin/cos, scaled vectors for atan2.
    logic cv_reg [0:CORDIC_STEPS];
    scc_pkg::cord_side_t cs_reg [0:CORDIC_STEPS];
    scc_pkg::cordic_t u0_reg [0:CORDIC_STEPS];
    scc_pkg::cordic_t u1_reg [0:CORDIC_STEPS];

    scc_pkg::cord_side_t ps_side;
    scc_pkg::cordic_t ps_u0;
    scc_pkg::cordic_t ps_u1;
    logic signed [scc_pkg::XY_W-1:0] x0;
    logic signed [scc_pkg::XY_W-1:0] y0;
    logic signed [scc_pkg::XY_W-1:0] x1;
    logic signed [scc_pkg::XY_W-1:0] y1;

    always_comb
    begin
        ps_side.cmd = rs_side_reg.cmd;
        ps_side.a = rs_side_reg.a;
        ps_side.th_neg = rs_side_reg.th.neg;
        ps_side.ps_neg = rs_side_reg.ps.neg;
        ps_side.zero0 = (rs_side_reg.c == 32'sd0) && (rs_rho_reg == 33'd0);
        ps_side.zero1 = (rs_side_reg.a == 32'sd0) && (rs_side_reg.b == 32'sd0);
        if (rs_r_reg > 33'h0_7FFF_FFFF)
        begin
            ps_side.r_clip = 32'h7FFF_FFFF;
            ps_side.sat = 1'b1;
        end
        else
        begin
            ps_side.r_clip = rs_r_reg[31:0];
            ps_side.sat = 1'b0;
        end
        ps_side.ok = (rs_side_reg.cmd == scc_pkg::CMD_CART2SPH) ? 1'b1 : rs_side_reg.ok;

        x0 = scc_pkg::XY_W'(rs_side_reg.c) <<< scc_pkg::PRESCALE_SH;
        y0 = scc_pkg::XY_W'(rs_rho_reg) <<< scc_pkg::PRESCALE_SH;
        ps_side.off0 = '0;
        if (x0 < 0)
        begin
            ps_side.off0 = scc_pkg::PI_Q28;
            x0 = -x0;
            y0 = -y0;
        end
        x1 = scc_pkg::XY_W'(rs_side_reg.a) <<< scc_pkg::PRESCALE_SH;
        y1 = scc_pkg::XY_W'(rs_side_reg.b) <<< scc_pkg::PRESCALE_SH;
        ps_side.off1 = '0;
        if (x1 < 0)
        begin
            ps_side.off1 = (y1 >= 0) ? scc_pkg::PI_Q28 : -scc_pkg::PI_Q28;
            x1 = -x1;
            y1 = -y1;
        end

        if (rs_side_reg.cmd == scc_pkg::CMD_SPH2CART)
        begin
            ps_u0.x = scc_pkg::GAIN_Q30;
            ps_u0.y = '0;
            ps_u0.z = rs_side_reg.th.z;
            ps_u1.x = scc_pkg::GAIN_Q30;
            ps_u1.y = '0;
            ps_u1.z = rs_side_reg.ps.z;
        end
        else
        begin
            ps_u0.x = x0;
            ps_u0.y = y0;
            ps_u0.z = '0;
            ps_u1.x = x1;
            ps_u1.y = y1;
            ps_u1.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            cv_reg[0] <= rs_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg[0] <= ps_side;
        u0_reg[0] <= ps_u0;
        u1_reg[0] <= ps_u1;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            cs_reg[i+1] <= cs_reg[i];
            u0_reg[i+1] <= scc_pkg::cordic_step(u0_reg[i],
                cs_reg[i].cmd == scc_pkg::CMD_SPH2CART, i);
            u1_reg[i+1] <= scc_pkg::cordic_step(u1_reg[i],
                cs_reg[i].cmd == scc_pkg::CMD_SPH2CART, i);
        end
    end

    // Undo the half-turn fold for sin/cos; add the quadrant offset for atan2.
    logic f_v_reg;
    scc_pkg::cord_side_t f_side_reg;
    logic signed [33:0] f_ct_reg;
    logic signed [33:0] f_st_reg;
    logic signed [33:0] f_cp_reg;
    logic signed [33:0] f_sp_reg;
    logic [31:0] f_ang0_reg;
    logic [31:0] f_ang1_reg;
    logic signed [33:0] f_ct_next;
    logic signed [33:0] f_st_next;
    logic signed [33:0] f_cp_next;
    logic signed [33:0] f_sp_next;
    scc_pkg::cordic_t ue0;
    scc_pkg::cordic_t ue1;
    scc_pkg::cord_side_t ce;

    always_comb
    begin
        ue0 = u0_reg[CORDIC_STEPS];
        ue1 = u1_reg[CORDIC_STEPS];
        ce = cs_reg[CORDIC_STEPS];
        f_ct_next = 34'(ue0.x);
        f_st_next = 34'(ue0.y);
        f_cp_next = 34'(ue1.x);
        f_sp_next = 34'(ue1.y);
        if (ce.th_neg)
        begin
            f_ct_next = -f_ct_next;
            f_st_next = -f_st_next;
        end
        if (ce.ps_neg)
        begin
            f_cp_next = -f_cp_next;
            f_sp_next = -f_sp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else
        begin
            f_v_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        f_side_reg <= ce;
        f_ct_reg <= f_ct_next;
        f_st_reg <= f_st_next;
        f_cp_reg <= f_cp_next;
        f_sp_reg <= f_sp_next;
        f_ang0_reg <= ce.zero0 ? 32'd0 : 32'(ce.off0 + ue0.z);
        f_ang1_reg <= ce.zero1 ? 32'd0 : 32'(ce.off1 + ue1.z);
    end

    // sin(theta) times cos(psi) and sin(psi).
    logic e1_v_reg;
    scc_pkg::cord_side_t e1_side_reg;
    logic signed [67:0] e1_pc_reg;
    logic signed [67:0] e1_ps_reg;
    logic signed [33:0] e1_ct_reg;
    logic [31:0] e1_ang0_reg;
    logic [31:0] e1_ang1_reg;

    // Round the products back to Q3.30.
    logic e2_v_reg;
    scc_pkg::cord_side_t e2_side_reg;
    logic signed [33:0] e2_m1_reg;
    logic signed [33:0] e2_m2_reg;
    logic signed [33:0] e2_ct_reg;
    logic [31:0] e2_ang0_reg;
    logic [31:0] e2_ang1_reg;

    // Scale by the radius.
    logic e3_v_reg;
    scc_pkg::cord_side_t e3_side_reg;
    logic signed [65:0] e3_q1_reg;
    logic signed [65:0] e3_q2_reg;
    logic signed [65:0] e3_q3_reg;
    logic [31:0] e3_ang0_reg;
    logic [31:0] e3_ang1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            e3_v_reg <= 1'b0;
        end
        else
        begin
            e1_v_reg <= f_v_reg;
            e2_v_reg <= e1_v_reg;
            e3_v_reg <= e2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_side_reg <= f_side_reg;
        e1_pc_reg <= 68'(f_cp_reg) * 68'(f_st_reg);
        e1_ps_reg <= 68'(f_sp_reg) * 68'(f_st_reg);
        e1_ct_reg <= f_ct_reg;
        e1_ang0_reg <= f_ang0_reg;
        e1_ang1_reg <= f_ang1_reg;

        e2_side_reg <= e1_side_reg;
        e2_m1_reg <= 34'(scc_pkg::rnd30(e1_pc_reg));
        e2_m2_reg <= 34'(scc_pkg::rnd30(e1_ps_reg));
        e2_ct_reg <= e1_ct_reg;
        e2_ang0_reg <= e1_ang0_reg;
        e2_ang1_reg <= e1_ang1_reg;

        e3_side_reg <= e2_side_reg;
        e3_q1_reg <= 66'(e2_side_reg.a) * 66'(e2_m1_reg);
        e3_q2_reg <= 66'(e2_side_reg.a) * 66'(e2_m2_reg);
        e3_q3_reg <= 66'(e2_side_reg.a) * 66'(e2_ct_reg);
        e3_ang0_reg <= e2_ang0_reg;
        e3_ang1_reg <= e2_ang1_reg;
    end

    // Final rounding, clipping and mode select into the output registers.
    scc_pkg::clip_t cx;
    scc_pkg::clip_t cy;
    scc_pkg::clip_t cz;
    logic done_reg;
    logic [31:0] result_a_reg;
    logic [31:0] result_b_reg;
    logic [31:0] result_c_reg;
    logic in_range_reg;
    logic saturated_reg;
    logic [31:0] result_a_next;
    logic [31:0] result_b_next;
    logic [31:0] result_c_next;
    logic in_range_next;
    logic saturated_next;

    always_comb
    begin
        cx = scc_pkg::clip32(scc_pkg::rnd30(68'(e3_q1_reg)));
        cy = scc_pkg::clip32(scc_pkg::rnd30(68'(e3_q2_reg)));
        cz = scc_pkg::clip32(scc_pkg::rnd30(68'(e3_q3_reg)));
        if (e3_side_reg.cmd == scc_pkg::CMD_SPH2CART)
        begin
            result_a_next = cx.v;
            result_b_next = cy.v;
            result_c_next = cz.v;
            in_range_next = e3_side_reg.ok;
            saturated_next = cx.sat || cy.sat || cz.sat;
        end
        else
        begin
            result_a_next = e3_side_reg.r_clip;
            result_b_next = e3_ang0_reg;
            result_c_next = e3_ang1_reg;
            in_range_next = 1'b1;
            saturated_next = e3_side_reg.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= e3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_a_reg <= result_a_next;
        result_b_reg <= result_b_next;
        result_c_reg <= result_c_next;
        in_range_reg <= in_range_next;
        saturated_reg <= saturated_next;
    end

    assign done = done_reg;
    assign result_a = result_a_reg;
    assign result_b = result_b_reg;
    assign result_c = result_c_reg;
    assign in_range = in_range_reg;
    assign saturated = saturated_reg;

    // A result word only ever leaves for a word that was started.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result word without a matching start");

    // Cartesian input always passes the range check and gives a non-negative radius.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(cmd, LATENCY) == scc_pkg::CMD_CART2SPH))
        |-> (in_range && !result_a[31]))
        else $error("cartesian result with bad range flag or negative radius");

    // A clipped radius comes out at the top of the range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated && ($past(cmd, LATENCY) == scc_pkg::CMD_CART2SPH))
        |-> (result_a == 32'sh7FFF_FFFF))
        else $error("saturated radius not at maximum");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the spherical/cartesian converter with a bit-exact predictor.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 24;
    localparam int LATENCY = 42 + STEPS;
    localparam int RANDOM_WORDS = 700;
    localparam longint ANG_PI = 843314857;
    localparam longint ANG_2PI = 1686629713;
    localparam longint ANG_HALF_PI = 421657428;
    localparam longint CORDIC_GAIN = 652032874;
    localparam longint Q16_LIMIT = 2147483647;

    typedef struct {
        logic [31:0] ra;
        logic [31:0] rb;
        logic [31:0] rc;
        logic ok;
        logic sat;
    } vector_out_t;

    typedef struct {
        logic cmd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        bit typed;
        vector_out_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] operand_c;
    logic done;
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic signed [31:0] result_c;
    logic in_range;
    logic saturated;

    vector_out_t pending_vectors[$];
    bit failed;
    bit next_typed;
    vector_out_t next_want;

    spherical_cartesian_convert #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .operand_c(operand_c),
        .done(done),
        .result_a(result_a),
        .result_b(result_b),
        .result_c(result_c),
        .in_range(in_range),
        .saturated(saturated)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint angle_step(input int i);
        longint tab[10];
        tab = '{210828714, 124459457, 65760959, 33381290, 16755422,
                8385879, 4193963, 2097109, 1048571, 524287};
        if (i < 10)
        begin
            return tab[i];
        end
        if (i <= 28)
        begin
            return 64'sd1 <<< (28 - i);
        end
        return 0;
    endfunction

    // Shift right by 30 with rounding half away from zero.
    function automatic longint round30(input longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< 29)) >>> 30;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint clip16(input longint v, inout logic sat);
        if (v > Q16_LIMIT)
        begin
            sat = 1'b1;
            return Q16_LIMIT;
        end
        if (v < -Q16_LIMIT - 1)
        begin
            sat = 1'b1;
            return -Q16_LIMIT - 1;
        end
        return v;
    endfunction

    function automatic void rotate_sincos(input longint ang, output longint cs,
                                          output longint sn);
        bit flip;
        longint x;
        longint y;
        longint xs;
        longint ys;
        flip = 0;
        x = CORDIC_GAIN;
        y = 0;
        while (ang > ANG_PI) ang -= ANG_2PI;
        while (ang < -ANG_PI) ang += ANG_2PI;
        if (ang > ANG_HALF_PI)
        begin
            ang -= ANG_PI;
            flip = 1;
        end
        else if (ang < -ANG_HALF_PI)
        begin
            ang += ANG_PI;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (ang >= 0)
            begin
                x -= ys;
                y += xs;
                ang -= angle_step(i);
            end
            else
            begin
                x += ys;
                y -= xs;
                ang += angle_step(i);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic longint vector_atan2(input longint yy, input longint xx);
        longint x;
        longint y;
        longint z;
        longint off;
        longint xs;
        longint ys;
        x = xx * 1048576;
        y = yy * 1048576;
        z = 0;
        off = 0;
        if (xx == 0 && yy == 0)
        begin
            return 0;
        end
        if (x < 0)
        begin
            off = y >= 0 ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys;
                y -= xs;
                z += angle_step(i);
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= angle_step(i);
            end
        end
        return off + z;
    endfunction

    function automatic longint root_rounded(input longint unsigned v);
        longint unsigned res;
        longint unsigned bval;
        res = 0;
        bval = 64'd1 << 62;
        while (bval > v) bval >>= 2;
        while (bval != 0)
        begin
            if (v >= res + bval)
            begin
                v -= res + bval;
                res = (res >> 1) + bval;
            end
            else
            begin
                res >>= 1;
            end
            bval >>= 2;
        end
        if (v > res)
        begin
            res++;
        end
        return longint'(res);
    endfunction

    function automatic vector_out_t convert_vector(input logic op, input logic [31:0] ua,
                                                   input logic [31:0] ub, input logic [31:0] uc);
        vector_out_t o;
        longint a;
        longint b;
        longint c;
        longint ct;
        longint st;
        longint cp;
        longint sp;
        longint unsigned sq;
        a = longint'($signed(ua));
        b = longint'($signed(ub));
        c = longint'($signed(uc));
        o.ok = 1'b1;
        o.sat = 1'b0;
        if (op == scc_pkg::CMD_SPH2CART)
        begin
            rotate_sincos(b, ct, st);
            rotate_sincos(c, cp, sp);
            o.ra = 32'(clip16(round30(a * round30(cp * st)), o.sat));
            o.rb = 32'(clip16(round30(a * round30(sp * st)), o.sat));
            o.rc = 32'(clip16(round30(a * ct), o.sat));
            if (a < 0 || b < -ANG_PI || b > ANG_PI || c < -ANG_2PI || c > ANG_2PI)
            begin
                o.ok = 1'b0;
            end
        end
        else
        begin
            sq = longint'(a * a) + longint'(b * b);
            o.rb = 32'(vector_atan2(root_rounded(sq), c));
            o.ra = 32'(clip16(root_rounded(sq + longint'(c * c)), o.sat));
            o.rc = 32'(vector_atan2(b, a));
        end
        return o;
    endfunction

    // Monitor: record accepted words and check every strobed result.
    always @(posedge clk)
    begin
        vector_out_t w;
        if (rst_n && start && !busy)
        begin
            pending_vectors.push_back(next_typed ? next_want
                                      : convert_vector(cmd, operand_a, operand_b, operand_c));
        end
        if (rst_n && done)
        begin
            if (pending_vectors.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                failed = 1;
            end
            else
            begin
                w = pending_vectors.pop_front();
                if (result_a !== w.ra)
                begin
                    $display("%0t: result_a expected %h actual %h", $time, w.ra, result_a);
                    failed = 1;
                end
                if (result_b !== w.rb)
                begin
                    $display("%0t: result_b expected %h actual %h", $time, w.rb, result_b);
                    failed = 1;
                end
                if (result_c !== w.rc)
                begin
                    $display("%0t: result_c expected %h actual %h", $time, w.rc, result_c);
                    failed = 1;
                end
                if (in_range !== w.ok)
                begin
                    $display("%0t: in_range expected %b actual %b", $time, w.ok, in_range);
                    failed = 1;
                end
                if (saturated !== w.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, w.sat, saturated);
                    failed = 1;
                end
            end
        end
    end

    // Drive one word at the falling edge and hold it until the block takes it.
    task automatic send_word(input logic op, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input bit typed, input vector_out_t want,
                             input bit may_idle);
        while (may_idle && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd <= op;
        operand_a <= a;
        operand_b <= b;
        operand_c <= c;
        next_typed <= typed;
        next_want <= want;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_angle(input longint span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    initial
    begin
        stim_row_t rows[$];
        vector_out_t none;
        vector_out_t zero_ok;
        logic op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        int wait_cycles;

        none = '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0};
        zero_ok = none;
        failed = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = scc_pkg::CMD_SPH2CART;
        operand_a = '0;
        operand_b = '0;
        operand_c = '0;
        next_typed = 0;
        next_want = none;

        // Zero radius and zero vector are typed in; the rest go through the predictor.
        rows = '{
            '{scc_pkg::CMD_SPH2CART, 32'd0, 32'd0, 32'd0, 1, zero_ok},
            '{scc_pkg::CMD_CART2SPH, 32'd0, 32'd0, 32'd0, 1, zero_ok},
            '{scc_pkg::CMD_SPH2CART, 32'h0001_0000, 32'(ANG_HALF_PI), 32'd0, 0, none},
            '{scc_pkg::CMD_SPH2CART, 32'h7FFF_FFFF, 32'(ANG_PI), 32'(ANG_2PI), 0, none},
            '{scc_pkg::CMD_SPH2CART, 32'h7FFF_FFFF, 32'(-ANG_PI), 32'(-ANG_2PI), 0, none},
            '{scc_pkg::CMD_SPH2CART, 32'h7FFF_FFFF, 32'(ANG_PI + 1), 32'(ANG_2PI + 1),
              0, none},
            '{scc_pkg::CMD_SPH2CART, 32'h8000_0000, 32'(-ANG_PI - 1), 32'(-ANG_2PI - 1),
              0, none},
            '{scc_pkg::CMD_SPH2CART, 32'hFFFF_0000, 32'd123456789, 32'd987654321, 0, none},
            '{scc_pkg::CMD_SPH2CART, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, none},
            '{scc_pkg::CMD_SPH2CART, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, none},
            '{scc_pkg::CMD_SPH2CART, 32'h0100_0000, 32'(ANG_HALF_PI + 1),
              32'(-ANG_HALF_PI - 1), 0, none},
            '{scc_pkg::CMD_CART2SPH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none},
            '{scc_pkg::CMD_CART2SPH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
            '{scc_pkg::CMD_CART2SPH, 32'hFFFF_0000, 32'd0, 32'd0, 0, none},
            '{scc_pkg::CMD_CART2SPH, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 0, none},
            '{scc_pkg::CMD_CART2SPH, 32'd0, 32'd0, 32'hFFFF_0000, 0, none},
            '{scc_pkg::CMD_CART2SPH, 32'd0, 32'h0001_0000, 32'd0, 0, none},
            '{scc_pkg::CMD_CART2SPH, 32'd1, 32'hFFFF_FFFF, 32'd1, 0, none}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            send_word(rows[i].cmd, rows[i].a, rows[i].b, rows[i].c,
                      rows[i].typed, rows[i].want, 1);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 200)
            begin
                start <= 1'b0;
                while (pending_vectors.size() != 0) @(negedge clk);
            end
            op = $urandom_range(1) ? scc_pkg::CMD_CART2SPH : scc_pkg::CMD_SPH2CART;
            a = $urandom;
            b = $urandom;
            c = $urandom;
            if ($urandom_range(99) < 65)
            begin
                // Mostly plausible vectors: modest magnitudes and in-range angles.
                a = 32'($signed(a) >>> $urandom_range(20));
                if (op == scc_pkg::CMD_SPH2CART)
                begin
                    a[31] = 1'b0;
                    b = random_angle(ANG_PI);
                    c = random_angle(ANG_2PI);
                end
                else
                begin
                    b = 32'($signed(b) >>> $urandom_range(20));
                    c = 32'($signed(c) >>> $urandom_range(20));
                end
            end
            // No idling on a stretch in the middle of the run.
            send_word(op, a, b, c, 0, none, !(n >= 350 && n < 500));
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_vectors.size() != 0 && wait_cycles < 10 * LATENCY)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(negedge clk);
        if (!failed && pending_vectors.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/scc_pkg.sv
rtl/core/spherical_cartesian_convert.sv
bench/testbench.sv
